[src/stab_pkg.sv]
package stab_pkg;

  // table geometry
  localparam int SLOTS   = 64;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);

  // word field widths
  localparam int ACT_W   = 3;
  localparam int KEY_W   = 16;
  localparam int SAL_W   = 20;
  localparam int GRP_W   = 8;
  localparam int STAT_W  = 2;
  localparam int SIDX_W  = 6;
  localparam int TOT_W   = 26;
  localparam int VCNT_W  = 7;

  // exact running total: a value times the slot count always fits
  localparam int ACC_W   = SAL_W + CNT_W;

  // command codes
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADD    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FIND   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_STATS  = 3'd4;

  // result codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clear_tbl;
    logic start;
    logic step;
    logic accum;
    logic compare;
    logic commit_hit;
    logic commit_miss;
    logic finish_stats;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] op;
    logic             hit;
    logic             last;
  } dp_stat_t;

endpackage

[src/stab_ctrl.sv]
module stab_ctrl
  import stab_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SUM,
    S_CMP,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.op) inside
          ACT_CLEAR: begin
            cmd.clear_tbl = 1'b1;
            state_next    = S_RESP;
          end
          ACT_ADD, ACT_FIND, ACT_REMOVE: begin
            cmd.start  = 1'b1;
            state_next = S_SCAN;
          end
          ACT_STATS: begin
            cmd.start  = 1'b1;
            state_next = S_SUM;
          end
          default: state_next = S_RESP;
        endcase
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (stat.hit) begin
          cmd.commit_hit = 1'b1;
          state_next     = S_RESP;
        end else if (stat.last) begin
          cmd.commit_miss = 1'b1;
          state_next      = S_RESP;
        end
      end
      S_SUM: begin
        cmd.step  = 1'b1;
        cmd.accum = 1'b1;
        if (stat.last) begin
          cmd.start  = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.step    = 1'b1;
        cmd.compare = 1'b1;
        if (stat.last) begin
          cmd.finish_stats = 1'b1;
          state_next       = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[src/stab_dp.sv]
module stab_dp
  import stab_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [ACT_W-1:0]  action,
  input  logic [KEY_W-1:0]  key_id,
  input  logic [SAL_W-1:0]  salary,
  input  logic [GRP_W-1:0]  group_no,
  output logic [STAT_W-1:0] status,
  output logic [SIDX_W-1:0] slot_index,
  output logic [SAL_W-1:0]  found_salary,
  output logic [GRP_W-1:0]  found_group,
  output logic [TOT_W-1:0]  salary_total,
  output logic [VCNT_W-1:0] valid_count,
  output logic [VCNT_W-1:0] above_mean_count
);

  // held command word
  logic [ACT_W-1:0] op;
  logic [KEY_W-1:0] in_key;
  logic [SAL_W-1:0] in_sal;
  logic [GRP_W-1:0] in_grp;

  // table storage
  logic [SLOTS-1:0] vbits;
  logic [KEY_W-1:0] mem_key [SLOTS];
  logic [SAL_W-1:0] mem_sal [SLOTS];
  logic [GRP_W-1:0] mem_grp [SLOTS];

  // scan counter and read stage
  logic [IDX_W:0]   cnt;
  logic [IDX_W-1:0] rd_addr;
  logic             cnt_live;
  logic             pipe_live;
  logic [IDX_W-1:0] pipe_idx;
  logic             pipe_vbit;
  logic [KEY_W-1:0] rd_key;
  logic [SAL_W-1:0] rd_sal;
  logic [GRP_W-1:0] rd_grp;

  // result and statistics
  logic [STAT_W-1:0] res_status;
  logic [IDX_W-1:0]  res_idx;
  logic [SAL_W-1:0]  res_sal;
  logic [GRP_W-1:0]  res_grp;
  logic              stats_ok;
  logic [ACC_W-1:0]  acc_total;
  logic [CNT_W-1:0]  acc_count;
  logic [CNT_W-1:0]  acc_above;
  logic [ACC_W-1:0]  product;
  logic              slot_hit;

  assign rd_addr  = cnt[IDX_W-1:0];
  assign cnt_live = (cnt < (IDX_W+1)'(SLOTS));
  assign product  = ACC_W'(rd_sal) * ACC_W'(acc_count);

  // add wants a free slot, find and remove a live slot with the key
  always_comb begin
    if (op == ACT_ADD) begin
      slot_hit = !pipe_vbit;
    end else begin
      slot_hit = pipe_vbit && (rd_key == in_key);
    end
  end

  assign stat.op   = op;
  assign stat.hit  = pipe_live && slot_hit;
  assign stat.last = pipe_live && (pipe_idx == IDX_W'(SLOTS - 1));

  // record memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit_hit && (op == ACT_ADD)) begin
      mem_key[pipe_idx] <= in_key;
      mem_sal[pipe_idx] <= in_sal;
      mem_grp[pipe_idx] <= in_grp;
    end
    rd_key <= mem_key[rd_addr];
    rd_sal <= mem_sal[rd_addr];
    rd_grp <= mem_grp[rd_addr];
  end

  // valid bits and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits     <= '0;
      pipe_live <= 1'b0;
      cnt       <= '0;
    end else begin
      if (cmd.clear_tbl) begin
        vbits <= '0;
      end else if (cmd.commit_hit && (op == ACT_ADD)) begin
        vbits[pipe_idx] <= 1'b1;
      end else if (cmd.commit_hit && (op == ACT_REMOVE)) begin
        vbits[pipe_idx] <= 1'b0;
      end
      if (cmd.start) begin
        cnt       <= '0;
        pipe_live <= 1'b0;
      end else if (cmd.step && cnt_live) begin
        cnt       <= cnt + 1'b1;
        pipe_live <= 1'b1;
      end else begin
        pipe_live <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx  <= rd_addr;
    pipe_vbit <= vbits[rd_addr];
  end

  // held word, results and statistics
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= action;
      in_key     <= key_id;
      in_sal     <= salary;
      in_grp     <= group_no;
      res_status <= ST_OK;
      res_idx    <= '0;
      res_sal    <= '0;
      res_grp    <= '0;
      stats_ok   <= 1'b0;
      acc_total  <= '0;
      acc_count  <= '0;
      acc_above  <= '0;
    end else begin
      if (cmd.commit_hit) begin
        res_idx <= pipe_idx;
        if (op == ACT_FIND) begin
          res_sal <= rd_sal;
          res_grp <= rd_grp;
        end
      end
      if (cmd.commit_miss) begin
        res_status <= (op == ACT_ADD) ? ST_FULL : ST_NOT_FOUND;
      end
      if (cmd.accum && pipe_live && pipe_vbit) begin
        acc_total <= acc_total + ACC_W'(rd_sal);
        acc_count <= acc_count + 1'b1;
      end
      if (cmd.compare && pipe_live && pipe_vbit && (product > acc_total)) begin
        acc_above <= acc_above + 1'b1;
      end
      if (cmd.finish_stats) begin
        if (acc_count == '0) begin
          res_status <= ST_EMPTY;
        end else begin
          stats_ok <= 1'b1;
        end
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status           <= res_status;
      slot_index       <= SIDX_W'(res_idx);
      found_salary     <= res_sal;
      found_group      <= res_grp;
      salary_total     <= stats_ok ? TOT_W'(acc_total) : '0;
      valid_count      <= stats_ok ? VCNT_W'(acc_count) : '0;
      above_mean_count <= stats_ok ? VCNT_W'(acc_above) : '0;
    end
  end

endmodule

[src/slot_table_allocate_find_free.sv]
// Channel | Handshake            | Word fields
// --------+----------------------+------------------------------------------------
// in      | in_valid / in_ready  | action, key_id, salary, group_no
// out     | out_valid / out_ready| status, slot_index, found_salary, found_group,
//         |                      | salary_total, valid_count, above_mean_count
//
// Order: one word at a time, from the accepting edge until the answer is loaded into
// the output register, after which the next word can be accepted: clear and unused
// codes go straight to the response step, add, find and remove scan up to a hit or the
// last slot, stats runs a summing pass, then a compare pass, one slot a cycle each.
// Reset: synchronous, active high; marks every slot free at once.
// Stalls: hold in the response step while the output register is still occupied.
module slot_table_allocate_find_free
  import stab_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ACT_W-1:0]  action,
  input  logic [KEY_W-1:0]  key_id,
  input  logic [SAL_W-1:0]  salary,
  input  logic [GRP_W-1:0]  group_no,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output logic [SIDX_W-1:0] slot_index,
  output logic [SAL_W-1:0]  found_salary,
  output logic [GRP_W-1:0]  found_group,
  output logic [TOT_W-1:0]  salary_total,
  output logic [VCNT_W-1:0] valid_count,
  output logic [VCNT_W-1:0] above_mean_count
);

  // command and status between the sequencer and the table datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: accept a word, drive the scan passes, hand over the result
  stab_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: valid bits, record memory, scan stage, totals, output register
  stab_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .action           (action),
    .key_id           (key_id),
    .salary           (salary),
    .group_no         (group_no),
    .status           (status),
    .slot_index       (slot_index),
    .found_salary     (found_salary),
    .found_group      (found_group),
    .salary_total     (salary_total),
    .valid_count      (valid_count),
    .above_mean_count (above_mean_count)
  );

endmodule
